// ===== design/gmr_pkg.sv =====
package gmr_pkg;

   // Largest grid that the block can hold.
   localparam int MAX_ROWS   = 16;
   localparam int MAX_COLS   = 16;
   localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;

   // Index widths follow from the grid limits.
   localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int NR_W   = $clog2(MAX_ROWS + 1);
   localparam int NC_W   = $clog2(MAX_COLS + 1);
   localparam int ADDR_W = $clog2(CELL_COUNT);
   localparam int CNT_W  = $clog2(CELL_COUNT + 1);

   // Fixed register field widths.
   localparam int DIM_W      = 5;
   localparam int POS_W      = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 5;

   typedef logic [ROW_W-1:0]  row_type;
   typedef logic [COL_W-1:0]  col_type;
   typedef logic [NR_W-1:0]   nr_type;
   typedef logic [NC_W-1:0]   nc_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [DIM_W-1:0]  dim_type;
   typedef logic [POS_W-1:0]  pos_type;

   // One stack entry: the grid position of a cell.
   typedef struct packed {
      row_type row;
      col_type col;
   } cell_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ROWS      = 3'd0,
      REG_COLS      = 3'd1,
      REG_START_ROW = 3'd2,
      REG_START_COL = 3'd3,
      REG_DEST_ROW  = 3'd4,
      REG_DEST_COL  = 3'd5
   } csr_reg_type;

   localparam dim_type RST_ROWS      = 5'd6;
   localparam dim_type RST_COLS      = 5'd6;
   localparam pos_type RST_START_ROW = 4'd0;
   localparam pos_type RST_START_COL = 4'd0;
   localparam pos_type RST_DEST_ROW  = 4'd5;
   localparam pos_type RST_DEST_COL  = 4'd5;

endpackage

// ===== design/gmr_ifs.sv =====
interface gmr_req_if;
   logic valid;
   logic ready;
   logic cell_value;
   logic last_cell;

   modport source (output valid, output cell_value, output last_cell, input ready);
   modport sink (input valid, input cell_value, input last_cell, output ready);
endinterface

interface gmr_rsp_if;
   logic valid;
   logic ready;
   logic reachable;

   modport source (output valid, output reachable, input ready);
   modport sink (input valid, input reachable, output ready);
endinterface

interface gmr_csr_if;
   logic                             valid;
   logic                             ready;
   logic [gmr_pkg::CSR_IDX_W-1:0]    index;
   logic [gmr_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/grid_maze_reachability_core.sv =====
// Channel   Direction  Payload                     Transfer when
// req_if    in         cell_value, last_cell       valid && ready
// rsp_if    out        reachable                   valid && ready
// csr_if    in         index (3 b), data (5 b)     valid && ready (ready is always high)
//
// Loading accepts one cell per cycle while req_if is ready, which is whenever no search is running.
// A last-cell transfer starts a search: a sweep first clears the visited flags of all
// rows*cols cells, then cells are popped from the stack until it runs empty or the
// destination turns up; each popped cell costs one stack read and four neighbour probes
// through the single read port of the cell memory.
// Reset is synchronous and active high; it restores the register defaults and the
// control state, but leaves the memories untouched.
// A stalled response holds in its output register; loading of the next grid carries
// on meanwhile, and a further search waits only at its end for the register to free.

module grid_maze_reachability_core (
   input logic         clock,
   input logic         reset,
   gmr_req_if.sink     req_if,
   gmr_rsp_if.source   rsp_if,
   gmr_csr_if.sink     csr_if
);

   // Search sequencer. Every state is one-hot coded.
   typedef enum logic [7:0] {
      S_LOAD    = 8'b0000_0001,
      S_CLEAR   = 8'b0000_0010,
      S_START   = 8'b0000_0100,
      S_SEED    = 8'b0000_1000,
      S_POP     = 8'b0001_0000,
      S_POPWAIT = 8'b0010_0000,
      S_EXPAND  = 8'b0100_0000,
      S_DONE    = 8'b1000_0000
   } state_type;

   typedef logic [2:0] step_type;
   localparam step_type STEP_RIGHT = 3'd0;
   localparam step_type STEP_LEFT  = 3'd1;
   localparam step_type STEP_DOWN  = 3'd2;
   localparam step_type STEP_UP    = 3'd3;
   localparam step_type STEP_LAST  = 3'd4;

   // One entry of the cell memory: the wall bit and the visited flag of a cell.
   typedef struct packed {
      logic wall;
      logic seen;
   } entry_type;

   // Configuration registers.
   gmr_pkg::dim_type rows_ff, cols_ff;
   gmr_pkg::pos_type start_row_ff, start_col_ff, dest_row_ff, dest_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= gmr_pkg::RST_ROWS;
         cols_ff      <= gmr_pkg::RST_COLS;
         start_row_ff <= gmr_pkg::RST_START_ROW;
         start_col_ff <= gmr_pkg::RST_START_COL;
         dest_row_ff  <= gmr_pkg::RST_DEST_ROW;
         dest_col_ff  <= gmr_pkg::RST_DEST_COL;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            gmr_pkg::REG_ROWS:      rows_ff      <= csr_if.data[gmr_pkg::DIM_W-1:0];
            gmr_pkg::REG_COLS:      cols_ff      <= csr_if.data[gmr_pkg::DIM_W-1:0];
            gmr_pkg::REG_START_ROW: start_row_ff <= csr_if.data[gmr_pkg::POS_W-1:0];
            gmr_pkg::REG_START_COL: start_col_ff <= csr_if.data[gmr_pkg::POS_W-1:0];
            gmr_pkg::REG_DEST_ROW:  dest_row_ff  <= csr_if.data[gmr_pkg::POS_W-1:0];
            gmr_pkg::REG_DEST_COL:  dest_col_ff  <= csr_if.data[gmr_pkg::POS_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_if.ready = 1'b1;

   // Effective grid size: dimensions above the limit are clipped to it.
   gmr_pkg::nr_type nr;
   gmr_pkg::nc_type nc;
   logic [gmr_pkg::NR_W+gmr_pkg::NC_W-1:0] total_full;
   gmr_pkg::cnt_type total;

   always_comb begin
      nr = (32'(rows_ff) > gmr_pkg::MAX_ROWS) ? gmr_pkg::nr_type'(gmr_pkg::MAX_ROWS)
                                              : gmr_pkg::nr_type'(rows_ff);
      nc = (32'(cols_ff) > gmr_pkg::MAX_COLS) ? gmr_pkg::nc_type'(gmr_pkg::MAX_COLS)
                                              : gmr_pkg::nc_type'(cols_ff);
   end

   assign total_full = nr * nc;
   assign total      = gmr_pkg::cnt_type'(total_full);

   // Control and payload registers.
   state_type          state_ff, state_in;
   gmr_pkg::cnt_type   load_idx_ff, load_idx_in;
   gmr_pkg::cnt_type   clr_ff, clr_in;
   gmr_pkg::cnt_type   sp_ff, sp_in;
   step_type           step_ff, step_in;
   gmr_pkg::cell_type  cur_ff, cur_in;
   logic               result_ff, result_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_reach_ff, rsp_reach_in;

   // Probe pipeline: a neighbour address is issued to the cell memory, and judged against
   // the returned wall and visited bits in the next cycle.
   logic               probe_vld_ff, probe_vld_in;
   gmr_pkg::cell_type  probe_ff, probe_in;
   gmr_pkg::addr_type  probe_addr_ff;
   logic [gmr_pkg::ROW_W+gmr_pkg::NC_W-1:0] probe_addr_full;
   gmr_pkg::addr_type  probe_addr;

   entry_type          cell_rd_ff;
   gmr_pkg::cell_type  stack_rd_ff;

   logic               req_fire;
   logic               grid_we;
   logic               push;
   logic               vis_we;
   logic               vis_wdata;
   gmr_pkg::addr_type  vis_waddr;
   gmr_pkg::cnt_type   sp_dec;
   logic               slot_free;
   logic               start_ok;
   logic               dest_hit;

   assign req_fire  = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == S_LOAD);
   assign grid_we   = req_fire && (32'(load_idx_ff) < 32'(total));
   assign push      = probe_vld_ff && !cell_rd_ff.wall && !cell_rd_ff.seen;
   assign sp_dec    = sp_ff - gmr_pkg::cnt_type'(1);
   assign slot_free = !rsp_valid_ff || rsp_if.ready;

   assign start_ok = (32'(start_row_ff) < 32'(nr)) && (32'(start_col_ff) < 32'(nc));
   assign dest_hit = (32'(stack_rd_ff.row) == 32'(dest_row_ff)) &&
                     (32'(stack_rd_ff.col) == 32'(dest_col_ff));

   // Neighbour selection, in the order right, left, down, up. A neighbour that
   // falls outside the grid is simply not probed.
   always_comb begin
      probe_vld_in = 1'b0;
      probe_in     = cur_ff;
      if (state_ff == S_START) begin
         probe_vld_in = start_ok;
         probe_in.row = gmr_pkg::row_type'(start_row_ff);
         probe_in.col = gmr_pkg::col_type'(start_col_ff);
      end else if (state_ff == S_EXPAND) begin
         case (step_ff)
            STEP_RIGHT: begin
               probe_vld_in = (32'(cur_ff.col) + 32'd1) < 32'(nc);
               probe_in.col = cur_ff.col + gmr_pkg::col_type'(1);
            end
            STEP_LEFT: begin
               probe_vld_in = (cur_ff.col != '0);
               probe_in.col = cur_ff.col - gmr_pkg::col_type'(1);
            end
            STEP_DOWN: begin
               probe_vld_in = (32'(cur_ff.row) + 32'd1) < 32'(nr);
               probe_in.row = cur_ff.row + gmr_pkg::row_type'(1);
            end
            STEP_UP: begin
               probe_vld_in = (cur_ff.row != '0);
               probe_in.row = cur_ff.row - gmr_pkg::row_type'(1);
            end
            default: ;
         endcase
      end
   end

   // Row-major address of the probed cell.
   assign probe_addr_full = probe_in.row * nc + probe_in.col;
   assign probe_addr      = gmr_pkg::addr_type'(probe_addr_full);

   // The visited flags are swept to zero before a search and set on each push.
   always_comb begin
      vis_we    = 1'b0;
      vis_wdata = 1'b0;
      vis_waddr = probe_addr_ff;
      if (state_ff == S_CLEAR) begin
         vis_we    = (clr_ff < total);
         vis_waddr = clr_ff[gmr_pkg::ADDR_W-1:0];
      end else if (push) begin
         vis_we    = 1'b1;
         vis_wdata = 1'b1;
      end
   end

   // Two memories, both read every cycle with registered data. The cell memory holds
   // the wall bit and the visited flag of every cell and is written one bit at a time:
   // wall bits only while loading, flags only during a search, so the two writes never
   // meet. The four probes of one expansion are distinct cells, so a flag write never
   // meets a read of the same entry in the same cycle, and a stack push always
   // completes before the next pop reads.
   entry_type         cell_mem  [gmr_pkg::CELL_COUNT];
   gmr_pkg::cell_type stack_mem [gmr_pkg::CELL_COUNT];

   always_ff @(posedge clock) begin
      if (grid_we) begin
         cell_mem[load_idx_ff[gmr_pkg::ADDR_W-1:0]].wall <= req_if.cell_value;
      end else if (vis_we) begin
         cell_mem[vis_waddr].seen <= vis_wdata;
      end
      cell_rd_ff <= cell_mem[probe_addr];
   end

   always_ff @(posedge clock) begin
      if (push) begin
         stack_mem[sp_ff[gmr_pkg::ADDR_W-1:0]] <= probe_ff;
      end
      stack_rd_ff <= stack_mem[sp_dec[gmr_pkg::ADDR_W-1:0]];
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      load_idx_in  = load_idx_ff;
      clr_in       = clr_ff;
      sp_in        = sp_ff;
      step_in      = step_ff;
      cur_in       = cur_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_reach_in = rsp_reach_ff;

      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (req_fire) begin
         if (req_if.last_cell) begin
            load_idx_in = '0;
         end else if (grid_we) begin
            load_idx_in = load_idx_ff + gmr_pkg::cnt_type'(1);
         end
      end

      // A push bumps the stack pointer; it never coincides with a pop.
      if (push) begin
         sp_in = sp_ff + gmr_pkg::cnt_type'(1);
      end

      case (state_ff)
         S_LOAD: begin
            if (req_fire && req_if.last_cell) begin
               clr_in   = '0;
               state_in = S_CLEAR;
            end
         end
         S_CLEAR: begin
            sp_in = '0;
            if (clr_ff < total) begin
               clr_in = clr_ff + gmr_pkg::cnt_type'(1);
            end else begin
               state_in = S_START;
            end
         end
         S_START: begin
            state_in = S_SEED;
         end
         S_SEED: begin
            state_in = S_POP;
         end
         S_POP: begin
            if (sp_ff == '0) begin
               result_in = 1'b0;
               state_in  = S_DONE;
            end else begin
               sp_in    = sp_dec;
               state_in = S_POPWAIT;
            end
         end
         S_POPWAIT: begin
            cur_in = stack_rd_ff;
            if (dest_hit) begin
               result_in = 1'b1;
               state_in  = S_DONE;
            end else begin
               step_in  = STEP_RIGHT;
               state_in = S_EXPAND;
            end
         end
         S_EXPAND: begin
            if (step_ff == STEP_LAST) begin
               state_in = S_POP;
            end else begin
               step_in = step_ff + step_type'(1);
            end
         end
         S_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_reach_in = result_ff;
               state_in     = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         load_idx_ff  <= '0;
         clr_ff       <= '0;
         sp_ff        <= '0;
         step_ff      <= STEP_RIGHT;
         probe_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_idx_ff  <= load_idx_in;
         clr_ff       <= clr_in;
         sp_ff        <= sp_in;
         step_ff      <= step_in;
         probe_vld_ff <= probe_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      result_ff     <= result_in;
      rsp_reach_ff  <= rsp_reach_in;
      probe_ff      <= probe_in;
      probe_addr_ff <= probe_addr;
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.reachable = rsp_reach_ff;

endmodule

// ===== design/gmr_checker.sv =====
module gmr_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_last,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_reachable
);

   // A stalled response stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response withdrawn while stalled");

   // A stalled response keeps its value.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_reachable))
      else $error("response value changed while stalled");

   // Once the last cell is taken, the block stops loading while it searches.
   a_search_blocks_load: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> !req_ready)
      else $error("input taken right after the last cell");

   // A new response is only ever produced from the end of a search.
   a_rsp_after_search: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response appeared while the block was loading");

endmodule

bind grid_maze_reachability_core gmr_checker u_gmr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .req_last      (req_if.last_cell),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_reachable (rsp_if.reachable)
);

// ===== verif/tb_top.sv =====
module tb_top;

   typedef logic [gmr_pkg::CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [gmr_pkg::CSR_DATA_W-1:0] csr_data_type;

   // Register indexes that the block does not decode; writes to them must be ignored.
   localparam csr_idx_type REG_SPARE_LO = 3'd6;
   localparam csr_idx_type REG_SPARE_HI = 3'd7;

   // Cell transfers (loaded or search-starting) that the random part aims for.
   localparam int unsigned ITEM_TARGET   = 1450;
   // Idle cycles after the last result before the registers are touched again.
   localparam int unsigned SETTLE_CYCLES = 8;
   // Quiet time at the end: longer than the slowest search on a full grid.
   localparam int unsigned END_CYCLES    = 2200;
   // Length of the deliberate response hold-off that fills the block up.
   localparam int unsigned HOLD_CYCLES   = 400;
   // Hard limit on the run, several times the slowest correct run.
   localparam int unsigned CYCLE_LIMIT   = 1_000_000;

   // Keeps its own copy of the grid and the registers, predicts the answer of every
   // search and compares each result transfer with the oldest outstanding answer.
   class maze_scoreboard;
      bit               maze_bits [gmr_pkg::CELL_COUNT];
      bit               loaded    [gmr_pkg::CELL_COUNT];
      int unsigned      load_pos;
      gmr_pkg::dim_type rows_reg, cols_reg;
      gmr_pkg::pos_type srow_reg, scol_reg, drow_reg, dcol_reg;
      bit               answers_q[$];
      int unsigned      errors, searches, reachable_seen, useful_cells, reg_writes;

      function new();
         rows_reg = gmr_pkg::RST_ROWS;
         cols_reg = gmr_pkg::RST_COLS;
         srow_reg = gmr_pkg::RST_START_ROW;
         scol_reg = gmr_pkg::RST_START_COL;
         drow_reg = gmr_pkg::RST_DEST_ROW;
         dcol_reg = gmr_pkg::RST_DEST_COL;
      endfunction

      function int unsigned grid_rows();
         return (rows_reg > gmr_pkg::MAX_ROWS) ? gmr_pkg::MAX_ROWS : rows_reg;
      endfunction

      function int unsigned grid_cols();
         return (cols_reg > gmr_pkg::MAX_COLS) ? gmr_pkg::MAX_COLS : cols_reg;
      endfunction

      function void note_reg(csr_idx_type idx, csr_data_type data);
         reg_writes++;
         case (idx)
            gmr_pkg::REG_ROWS:      rows_reg = data;
            gmr_pkg::REG_COLS:      cols_reg = data;
            gmr_pkg::REG_START_ROW: srow_reg = data[gmr_pkg::POS_W-1:0];
            gmr_pkg::REG_START_COL: scol_reg = data[gmr_pkg::POS_W-1:0];
            gmr_pkg::REG_DEST_ROW:  drow_reg = data[gmr_pkg::POS_W-1:0];
            gmr_pkg::REG_DEST_COL:  dcol_reg = data[gmr_pkg::POS_W-1:0];
            default: ;
         endcase
      endfunction

      // True when every store position from first up to but not including limit has been loaded at least once.
      function bit tail_loaded(int unsigned first, int unsigned limit);
         for (int unsigned i = first; i < limit; i++)
            if (!loaded[i]) return 1'b0;
         return 1'b1;
      endfunction

      // Depth-first walk over open cells; the order of neighbours does not change the answer.
      function bit walk_maze();
         int nr, nc, r, c, rr, cc, pos, npos;
         bit seen [gmr_pkg::CELL_COUNT];
         int pend[$];
         nr = grid_rows();
         nc = grid_cols();
         if (srow_reg >= nr || scol_reg >= nc) return 1'b0;
         pos = srow_reg * nc + scol_reg;
         if (maze_bits[pos]) return 1'b0;
         seen[pos] = 1'b1;
         pend.push_back(pos);
         while (pend.size() != 0) begin
            pos = pend.pop_back();
            r = pos / nc;
            c = pos % nc;
            if (r == drow_reg && c == dcol_reg) return 1'b1;
            for (int d = 0; d < 4; d++) begin
               rr = r + ((d == 0) ? 1 : (d == 1) ? -1 : 0);
               cc = c + ((d == 2) ? 1 : (d == 3) ? -1 : 0);
               if (rr >= 0 && rr < nr && cc >= 0 && cc < nc) begin
                  npos = rr * nc + cc;
                  if (!maze_bits[npos] && !seen[npos]) begin
                     seen[npos] = 1'b1;
                     pend.push_back(npos);
                  end
               end
            end
         end
         return 1'b0;
      endfunction

      function void note_cell(bit wall, bit last);
         int unsigned total;
         bit answer;
         total = grid_rows() * grid_cols();
         if (load_pos < total) begin
            maze_bits[load_pos] = wall;
            loaded[load_pos] = 1'b1;
            load_pos++;
            useful_cells++;
         end else if (last) begin
            useful_cells++;
         end
         if (last) begin
            answer = walk_maze();
            answers_q.push_back(answer);
            searches++;
            reachable_seen += answer;
            load_pos = 0;
         end
      endfunction

      function void check_result(logic got);
         bit want;
         if (answers_q.size() == 0) begin
            $display("%0t: result transfer reachable=%b arrived with no search outstanding",
                     $time, got);
            errors++;
         end else begin
            want = answers_q.pop_front();
            if (got !== want) begin
               $display("%0t: reachable mismatch, expected %b, actual %b", $time, want, got);
               errors++;
            end
         end
      endfunction

      function int unsigned pending();
         return answers_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int unsigned cycle_count;
   int unsigned send_gap_pct;
   int unsigned rsp_hold_left;
   maze_scoreboard sb = new();

   gmr_req_if req_if ();
   gmr_rsp_if rsp_if ();
   gmr_csr_if csr_if ();

   grid_maze_reachability_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // All three channels are observed in one place at the rising edge, so that a cell
   // transfer is always noted before any result that it might cause is checked.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_if.valid && csr_if.ready) sb.note_reg(csr_if.index, csr_if.data);
         if (req_if.valid && req_if.ready) sb.note_cell(req_if.cell_value, req_if.last_cell);
         if (rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.reachable);
      end
   end

   // The watchdog ends a run that hangs; it counts cycles rather than waiting on time.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles with %0d results outstanding",
                  $time, CYCLE_LIMIT, sb.pending());
         $display("TEST FAILED");
         $finish;
      end
   end

   // Response side. The stall rate is redrawn each time its mode runs out, so that there are
   // stretches with no back-pressure at all as well as heavily stalled ones. A requested
   // hold-off takes priority and is counted down here, cycle by cycle.
   initial begin
      int unsigned stall_left, stall_pct, mode_left;
      rsp_if.ready = 1'b0;
      stall_left = 0;
      stall_pct = 0;
      mode_left = 0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            case ($urandom_range(0, 3))
               0, 1:    stall_pct = 0;
               2:       stall_pct = 15;
               default: stall_pct = 50;
            endcase
            mode_left = $urandom_range(50, 300);
         end else begin
            mode_left--;
         end
         if (rsp_hold_left > 0) begin
            rsp_if.ready = 1'b0;
            rsp_hold_left--;
         end else if (stall_left > 0) begin
            rsp_if.ready = 1'b0;
            stall_left--;
         end else if ($urandom_range(0, 99) < stall_pct) begin
            rsp_if.ready = 1'b0;
            stall_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80)
                                                      : $urandom_range(0, 3);
         end else begin
            rsp_if.ready = 1'b1;
         end
      end
   end

   // One register write; the transfer is noted by the monitor when it happens.
   task automatic write_reg(csr_idx_type idx, csr_data_type data);
      csr_if.valid = 1'b1;
      csr_if.index = idx;
      csr_if.data  = data;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   task automatic set_maze(int unsigned rows, int unsigned cols,
                           csr_data_type srow, csr_data_type scol,
                           csr_data_type drow, csr_data_type dcol);
      write_reg(gmr_pkg::REG_ROWS, rows[gmr_pkg::CSR_DATA_W-1:0]);
      write_reg(gmr_pkg::REG_COLS, cols[gmr_pkg::CSR_DATA_W-1:0]);
      write_reg(gmr_pkg::REG_START_ROW, srow);
      write_reg(gmr_pkg::REG_START_COL, scol);
      write_reg(gmr_pkg::REG_DEST_ROW, drow);
      write_reg(gmr_pkg::REG_DEST_COL, dcol);
   endtask

   // Streams one grid; the final cell carries the last flag and starts the search.
   // Valid stays high from one cell to the next unless a gap is drawn.
   task automatic send_maze(bit walls[$]);
      int unsigned gap;
      foreach (walls[i]) begin
         gap = 0;
         if ($urandom_range(0, 99) < send_gap_pct)
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
         if (gap > 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_if.valid      = 1'b1;
         req_if.cell_value = walls[i];
         req_if.last_cell  = (i == walls.size() - 1);
         do @(posedge clock); while (!req_if.ready);
         @(negedge clock);
      end
      req_if.valid = 1'b0;
   endtask

   // Bit i of the pattern is the i-th cell in row-major order.
   task automatic send_pattern(logic [15:0] pattern, int unsigned count);
      bit walls[$];
      for (int unsigned i = 0; i < count; i++) walls.push_back(pattern[i]);
      send_maze(walls);
   endtask

   task automatic wait_results();
      while (sb.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Registers are only rewritten once the block has nothing left to report.
   task automatic drain();
      wait_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Grid dimensions are mostly small so that searches are frequent; zero and values
   // above the grid limit appear now and then.
   function automatic int unsigned pick_dim();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 4) return 0;
      if (sel < 80) return $urandom_range(1, 5);
      if (sel < 94) return $urandom_range(6, 16);
      return $urandom_range(17, 31);
   endfunction

   // A position that is usually inside the grid; sometimes anywhere, and sometimes with
   // the unused top data bit set, which the block must drop.
   function automatic csr_data_type pick_pos(int unsigned span);
      csr_data_type pos;
      if (span == 0 || $urandom_range(0, 99) < 15) pos = csr_data_type'($urandom_range(0, 15));
      else pos = csr_data_type'($urandom_range(0, span - 1));
      if ($urandom_range(0, 99) < 15) pos[gmr_pkg::CSR_DATA_W-1] = 1'b1;
      return pos;
   endfunction

   // One random configuration followed by a few grids. Most grids are complete; some
   // carry surplus cells after the grid is full, and some end early and reuse what the
   // store already holds, which is only allowed where every remaining cell was loaded.
   task automatic run_random_phase();
      int unsigned rows, cols, total, grids, count, kind, wall_pct;
      csr_data_type srow, scol, drow, dcol;
      bit walls[$];
      rows  = pick_dim();
      cols  = pick_dim();
      total = ((rows > gmr_pkg::MAX_ROWS) ? gmr_pkg::MAX_ROWS : rows) *
              ((cols > gmr_pkg::MAX_COLS) ? gmr_pkg::MAX_COLS : cols);
      srow  = pick_pos((rows > gmr_pkg::MAX_ROWS) ? gmr_pkg::MAX_ROWS : rows);
      scol  = pick_pos((cols > gmr_pkg::MAX_COLS) ? gmr_pkg::MAX_COLS : cols);
      if ($urandom_range(0, 4) == 0) begin
         drow = srow;
         dcol = scol;
      end else begin
         drow = pick_pos((rows > gmr_pkg::MAX_ROWS) ? gmr_pkg::MAX_ROWS : rows);
         dcol = pick_pos((cols > gmr_pkg::MAX_COLS) ? gmr_pkg::MAX_COLS : cols);
      end
      if ($urandom_range(0, 9) == 0)
         write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_HI : REG_SPARE_LO,
                   csr_data_type'($urandom_range(0, 31)));
      set_maze(rows, cols, srow, scol, drow, dcol);
      case ($urandom_range(0, 3))
         0, 1:    send_gap_pct = 0;
         2:       send_gap_pct = 10;
         default: send_gap_pct = 35;
      endcase
      grids = (total > 64) ? $urandom_range(1, 2) : $urandom_range(2, 6);
      repeat (grids) begin
         wall_pct = $urandom_range(0, 45);
         kind     = $urandom_range(0, 99);
         count    = total;
         if (total == 0) begin
            count = $urandom_range(1, 4);
         end else if (kind < 10) begin
            count = total + $urandom_range(1, 4);
         end else if (kind < 20 && total > 1) begin
            count = $urandom_range(1, total - 1);
            if (!sb.tail_loaded(count, total)) count = total;
         end
         walls.delete();
         repeat (count) walls.push_back($urandom_range(0, 99) < wall_pct);
         send_maze(walls);
         // Now and then the sender waits for the answer before the next grid.
         if ($urandom_range(0, 9) == 0) wait_results();
      end
      drain();
   endtask

   initial begin
      reset             = 1'b1;
      cycle_count       = 0;
      send_gap_pct      = 0;
      rsp_hold_left     = 0;
      req_if.valid      = 1'b0;
      req_if.cell_value = 1'b0;
      req_if.last_cell  = 1'b0;
      csr_if.valid      = 1'b0;
      csr_if.index      = gmr_pkg::REG_ROWS;
      csr_if.data       = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // Directed part on a 2 by 2 grid: open path, walled-off destination, start equal to
      // destination, a start on a wall, an early last cell over the stored grid and a
      // start row beyond the grid. A write to an undecoded index must change nothing.
      write_reg(REG_SPARE_LO, 5'd3);
      set_maze(2, 2, 5'd0, 5'd0, 5'd1, 5'd1);
      send_pattern(16'b0000, 4);
      send_pattern(16'b0110, 4);
      drain();
      set_maze(2, 2, 5'd0, 5'd0, 5'd0, 5'd0);
      send_pattern(16'b1110, 4);
      drain();
      set_maze(2, 2, 5'd1, 5'd0, 5'd0, 5'd0);
      send_pattern(16'b0100, 4);
      drain();
      // Only the first cell is replaced; the rest of the previous grid stays in the store.
      set_maze(2, 2, 5'd0, 5'd0, 5'd1, 5'd1);
      send_pattern(16'b0, 1);
      drain();
      set_maze(2, 2, 5'h1F, 5'd0, 5'd1, 5'd1);
      send_pattern(16'b0000, 4);
      drain();
      // A grid with no rows stores nothing and answers no.
      set_maze(0, 3, 5'd0, 5'd0, 5'd0, 5'd0);
      send_pattern(16'b00, 2);
      drain();

      // Back-pressure: the response side holds off while tiny grids keep coming, so
      // that a finished answer sits in the output register, the next search waits for
      // it and cell transfers stop being accepted.
      set_maze(1, 2, 5'd0, 5'd0, 5'd0, 5'd1);
      send_gap_pct  = 0;
      rsp_hold_left = HOLD_CYCLES;
      repeat (10) send_pattern(16'($urandom_range(0, 3)), 2);
      drain();

      while (sb.useful_cells < ITEM_TARGET || sb.searches < 48) run_random_phase();

      wait_results();
      repeat (END_CYCLES) @(negedge clock);
      if (sb.pending() != 0) begin
         $display("%0t: %0d searches never answered", $time, sb.pending());
         sb.errors += sb.pending();
      end

      $display("Covered %0d searches (%0d reachable) over %0d cell transfers",
               sb.searches, sb.reachable_seen, sb.useful_cells);
      $display("with %0d register writes, in %0d cycles", sb.reg_writes, cycle_count);
      if (sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

// ===== grid_maze_reachability_core.f =====
design/gmr_pkg.sv
design/gmr_ifs.sv
design/grid_maze_reachability_core.sv
design/gmr_checker.sv
verif/tb_top.sv
